// ----- design/rpsn_pkg.sv -----
package rpsn_pkg;

  // Field widths of the sample channels.
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SAMPLE_W = 16;

  // Configuration port: register index and data widths.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_SAMPLES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LITTLE_ENDIAN = 2'd2;

  // Sample format codes.
  localparam logic [2:0] FMT_SIGNED   = 3'd0;
  localparam logic [2:0] FMT_UNSIGNED = 3'd1;
  localparam logic [2:0] FMT_SIGN_BIT = 3'd2;
  localparam logic [2:0] FMT_ULAW     = 3'd3;
  localparam logic [2:0] FMT_ALAW     = 3'd4;

  // G.711 expansion constants.
  localparam logic [SAMPLE_W-1:0] ULAW_BIAS   = 16'h0084;
  localparam logic [SAMPLE_W-1:0] ALAW_OFFSET = 16'h0108;
  localparam logic [SAMPLE_W-1:0] ALAW_SEG0   = 16'h0008;
  localparam logic [BYTE_W-1:0]   ALAW_XOR    = 8'h55;

  // Sign bit masks for the linear formats.
  localparam logic [SAMPLE_W-1:0] SIGN16 = 16'h8000;
  localparam logic [BYTE_W-1:0]   SIGN8  = 8'h80;

  typedef logic [2:0] fmt_t;

endpackage

// ----- design/rpsn_if.sv -----
// Raw sample input channel.
interface rpsn_in_if
  import rpsn_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] first_byte;
  logic [BYTE_W-1:0] second_byte;
  logic              last_in;

  modport source (output valid, first_byte, second_byte, last_in, input ready);
  modport sink   (input valid, first_byte, second_byte, last_in, output ready);
endinterface

// Normalised sample output channel.
interface rpsn_out_if
  import rpsn_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_out;
  logic                last_out;

  modport source (output valid, sample_out, last_out, input ready);
  modport sink   (input valid, sample_out, last_out, output ready);
endinterface

// ----- design/raw_pcm_sample_normalizer.sv -----
// Raw PCM sample normaliser.
// Each input transaction on in_ch carries one raw sample as its first and
// second stream bytes plus a last-sample marker. Each output transaction on
// out_ch carries the sample in wave-native form: 8-bit samples offset-
// unsigned in the low byte, 16-bit samples in two's complement, and u-law or
// A-law codes expanded to 16-bit linear. The marker is passed through.
// The format, sample width and byte order are set through the cfg_ write
// port, and should only be changed while no transaction is in flight.
// An accepted sample passes through one input register and then one result
// register, with the conversion logic between them.
// Throughput is one sample per cycle; both registers advance together, so a
// new sample is taken every cycle while out_ch is being drained.
// When the receiver stalls, the result register holds its sample and the
// input register fills; in_ch.ready then drops until out_ch moves again.
// Reset clears both valid flags and loads the defaults: signed format,
// 16-bit samples, little-endian byte order.
module raw_pcm_sample_normalizer
  import rpsn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rpsn_in_if.sink               in_ch,
  rpsn_out_if.source            out_ch
);

  // Configuration registers.
  fmt_t format_r;
  logic wide_r;
  logic le_r;

  // Input stage.
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_b0_r;
  logic [BYTE_W-1:0] s1_b1_r;
  logic              s1_last_r;

  // Result stage.
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_sample_r;
  logic                out_last_r;

  logic                s2_load;
  logic                s1_load;
  logic [SAMPLE_W-1:0] word;
  logic [SAMPLE_W-1:0] result_nxt;

  // u-law expansion of one code byte.
  function automatic logic [SAMPLE_W-1:0] expand_ulaw(input logic [BYTE_W-1:0] code);
    logic [BYTE_W-1:0]   v;
    logic [SAMPLE_W-1:0] mag;
    v   = ~code;
    mag = ({9'd0, v[3:0], 3'd0} + ULAW_BIAS) << v[6:4];
    return v[7] ? (ULAW_BIAS - mag) : (mag - ULAW_BIAS);
  endfunction

  // A-law expansion of one code byte.
  function automatic logic [SAMPLE_W-1:0] expand_alaw(input logic [BYTE_W-1:0] code);
    logic [BYTE_W-1:0]   v;
    logic [SAMPLE_W-1:0] mag;
    logic [2:0]          seg_m1;
    v      = code ^ ALAW_XOR;
    seg_m1 = v[6:4] - 3'd1;
    if (v[6:4] == 3'd0) begin
      mag = {8'd0, v[3:0], 4'd0} + ALAW_SEG0;
    end else begin
      mag = ({8'd0, v[3:0], 4'd0} + ALAW_OFFSET) << seg_m1;
    end
    // Bit 7 set after the xor means a positive sample.
    return v[7] ? mag : (SAMPLE_W'(0) - mag);
  endfunction

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_r <= FMT_SIGNED;
      wide_r   <= 1'b1;
      le_r     <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAMPLE_FORMAT: format_r <= cfg_data;
        REG_WIDE_SAMPLES:  wide_r   <= cfg_data[0];
        REG_LITTLE_ENDIAN: le_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Handshake: the result register loads when empty or being drained, and
  // the input register loads when empty or passing its sample on.
  assign s2_load     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s2_load;
  assign s1_load     = in_ch.valid && in_ch.ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_b0_r   <= in_ch.first_byte;
      s1_b1_r   <= in_ch.second_byte;
      s1_last_r <= in_ch.last_in;
    end
  end

  // Assemble the 16-bit word in stream byte order.
  assign word = le_r ? {s1_b1_r, s1_b0_r} : {s1_b0_r, s1_b1_r};

  // Conversion to wave-native form.
  always_comb begin
    result_nxt = '0;
    unique case (format_r)
      FMT_SIGNED: begin
        result_nxt = wide_r ? word : {8'd0, s1_b0_r ^ SIGN8};
      end
      FMT_UNSIGNED: begin
        result_nxt = wide_r ? (word ^ SIGN16) : {8'd0, s1_b0_r};
      end
      FMT_SIGN_BIT: begin
        // Negative codes invert their magnitude bits.
        if (wide_r) begin
          result_nxt = word[15] ? {1'b1, ~word[14:0]} : word;
        end else begin
          result_nxt = {8'd0, s1_b0_r[7] ? ~s1_b0_r : (s1_b0_r ^ SIGN8)};
        end
      end
      FMT_ULAW: result_nxt = expand_ulaw(s1_b0_r);
      FMT_ALAW: result_nxt = expand_alaw(s1_b0_r);
      default:  result_nxt = '0;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_sample_r <= result_nxt;
      out_last_r   <= s1_last_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_sample_r;
  assign out_ch.last_out   = out_last_r;

  // A sample passed on from the input register is shown on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    s2_load |=> out_valid_r)
    else $error("result register did not take the input stage sample");

  // The marker follows its sample through the result register.
  assert property (@(posedge clk) disable iff (!rst_n)
    s2_load |=> (out_last_r == $past(s1_last_r)))
    else $error("last marker lost between stages");

  // The input side is never blocked while the input register is empty.
  assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ch.ready)
    else $error("input stalled with an empty input register");

  // Undefined format codes give a zero sample.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && format_r != FMT_SIGNED && format_r != FMT_UNSIGNED &&
     format_r != FMT_SIGN_BIT && format_r != FMT_ULAW && format_r != FMT_ALAW)
    |-> (out_sample_r == '0))
    else $error("undefined format produced a non-zero sample");

endmodule
